[rtl/core/bed_pkg.sv]
package bed_pkg;

  // Character codes used by the escape decoder
  localparam logic [7:0] ChrBsl   = 8'h5c;
  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrSeven = 8'h37;
  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [7:0] LowX     = 8'h78;
  localparam logic [7:0] LowU     = 8'h75;
  localparam logic [7:0] LowC     = 8'h63;

  // Most result items one input item can cause
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // Short ordered list of output bytes
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic [MaxRes-1:0][7:0]   data;
  } seq_t;

  // All result items of one input item
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    logic [MaxRes-1:0][7:0]   data;
    logic                     has;
    logic                     last;
  } res_t;

  // Hex digit value in the low nibble, bit 4 set for a non-digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end
    return v;
  endfunction

  // Letter escapes to control codes, other bytes unchanged
  function automatic logic [7:0] letter_code(input logic [7:0] b);
    logic [7:0] r;
    case (b | CaseBit)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = 8'd27;
      8'h66:   r = 8'd12;
      8'h6e:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic seq_t seq_one(input logic [7:0] b);
    seq_t s;
    s = '0;
    s.cnt = CntW'(1);
    s.data[0] = b;
    return s;
  endfunction

  // UTF-8 encoding of a 16-bit code point
  function automatic seq_t utf8(input logic [15:0] x);
    seq_t s;
    s = '0;
    if (|(x & 16'hf800)) begin
      s.cnt = CntW'(3);
      s.data[0] = 8'he0 | {4'h0, x[15:12]};
      s.data[1] = 8'h80 | {2'b00, x[11:6]};
      s.data[2] = 8'h80 | {2'b00, x[5:0]};
    end else if (|(x & 16'hff80)) begin
      s.cnt = CntW'(2);
      s.data[0] = 8'hc0 | {3'b000, x[10:6]};
      s.data[1] = 8'h80 | {2'b00, x[5:0]};
    end else begin
      s.cnt = CntW'(1);
      s.data[0] = x[7:0];
    end
    return s;
  endfunction

  // Append b after a, keeping at most MaxRes bytes
  function automatic seq_t seq_cat(input seq_t a, input seq_t b);
    seq_t r;
    logic [CntW-1:0] idx;
    logic [CntW:0] sum;
    r = '0;
    for (int i = 0; i < MaxRes; i++) begin
      idx = CntW'(i) - a.cnt;
      if (CntW'(i) < a.cnt) begin
        r.data[i] = a.data[i];
      end else begin
        r.data[i] = b.data[idx[$clog2(MaxRes)-1:0]];
      end
    end
    sum = {1'b0, a.cnt} + {1'b0, b.cnt};
    r.cnt = (sum > (CntW + 1)'(MaxRes)) ? CntW'(MaxRes) : sum[CntW-1:0];
    return r;
  endfunction

endpackage

[rtl/core/bed_decode.sv]
module bed_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output bed_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    PhIdle = 4'd0,
    PhBsl  = 4'd1,
    PhCtrl = 4'd2,
    PhOct1 = 4'd3,
    PhOct2 = 4'd4,
    PhHex0 = 4'd5,
    PhHex1 = 4'd6,
    PhU0   = 4'd7,
    PhU1   = 4'd8,
    PhU2   = 4'd9,
    PhU3   = 4'd10
  } phase_e;

  phase_e        phase_q, phase_d, phase_n;
  logic [15:0]   acc_q, acc_d, acc_n;
  logic [7:0]    letter_q, letter_d, letter_n;

  logic          retry;
  logic [7:0]    oct;
  logic [7:0]    acc8;
  logic [15:0]   acc16;
  logic [4:0]    hv;
  bed_pkg::seq_t p1, p2, fl, tail, all_s;

  // First pass over the byte from the current phase
  always_comb begin
    p1       = '0;
    retry    = 1'b0;
    phase_d  = PhIdle;
    acc_d    = '0;
    letter_d = '0;
    oct      = byte_i ^ bed_pkg::ChrZero;
    acc8     = {acc_q[4:0], oct[2:0]};
    hv       = bed_pkg::hex_val(byte_i);
    acc16    = {acc_q[11:0], hv[3:0]};
    case (phase_q)
      PhBsl: begin
        if (byte_i >= bed_pkg::ChrZero && byte_i <= bed_pkg::ChrSeven) begin
          acc_d   = {13'b0, byte_i[2:0]};
          phase_d = PhOct1;
        end else if ((byte_i | bed_pkg::CaseBit) == bed_pkg::LowX) begin
          letter_d = byte_i;
          phase_d  = PhHex0;
        end else if ((byte_i | bed_pkg::CaseBit) == bed_pkg::LowU) begin
          letter_d = byte_i;
          phase_d  = PhU0;
        end else if ((byte_i | bed_pkg::CaseBit) == bed_pkg::LowC) begin
          phase_d = PhCtrl;
        end else if (byte_i[7]) begin
          p1 = bed_pkg::seq_one(byte_i);
        end else begin
          p1 = bed_pkg::seq_one(bed_pkg::letter_code(byte_i));
        end
      end
      PhCtrl: begin
        p1 = bed_pkg::seq_one({3'b000, byte_i[4:0]});
      end
      PhOct1, PhOct2: begin
        if (|oct[7:3]) begin
          p1    = bed_pkg::seq_one(acc_q[7:0]);
          retry = 1'b1;
        end else if (phase_q == PhOct2) begin
          p1 = bed_pkg::seq_one(acc8);
        end else begin
          acc_d    = {8'h00, acc8};
          letter_d = letter_q;
          phase_d  = PhOct2;
        end
      end
      PhHex0, PhU0: begin
        if (hv[4]) begin
          p1    = bed_pkg::seq_one(letter_q);
          retry = 1'b1;
        end else begin
          acc_d    = {12'h000, hv[3:0]};
          letter_d = letter_q;
          phase_d  = (phase_q == PhHex0) ? PhHex1 : PhU1;
        end
      end
      PhHex1: begin
        if (hv[4]) begin
          p1    = bed_pkg::seq_one(acc_q[7:0]);
          retry = 1'b1;
        end else begin
          p1 = bed_pkg::seq_one({acc_q[3:0], hv[3:0]});
        end
      end
      PhU1, PhU2, PhU3: begin
        if (hv[4]) begin
          p1    = bed_pkg::utf8(acc_q);
          retry = 1'b1;
        end else if (phase_q == PhU3) begin
          p1 = bed_pkg::utf8(acc16);
        end else begin
          acc_d    = acc16;
          letter_d = letter_q;
          phase_d  = (phase_q == PhU1) ? PhU2 : PhU3;
        end
      end
      default: begin
        if (byte_i == bed_pkg::ChrBsl) begin
          phase_d = PhBsl;
        end else begin
          p1 = bed_pkg::seq_one(byte_i);
        end
      end
    endcase

    // Handle the byte that ended a numeric escape afresh from idle
    p2 = '0;
    if (retry) begin
      if (byte_i == bed_pkg::ChrBsl) begin
        phase_d = PhBsl;
      end else begin
        p2 = bed_pkg::seq_one(byte_i);
      end
    end
  end

  // Flush an escape still open at the end of the string
  always_comb begin
    case (phase_d)
      PhOct1, PhOct2, PhHex1: fl = bed_pkg::seq_one(acc_d[7:0]);
      PhHex0, PhU0:           fl = bed_pkg::seq_one(letter_d);
      PhU1, PhU2, PhU3:       fl = bed_pkg::utf8(acc_d);
      default:                fl = '0;
    endcase
  end

  // Gather the result items of this byte
  always_comb begin
    if (retry) begin
      tail = p2;
    end else if (last_i) begin
      tail = fl;
    end else begin
      tail = '0;
    end
    all_s      = bed_pkg::seq_cat(p1, tail);
    res_o.data = all_s.data;
    res_o.has  = (all_s.cnt != '0);
    res_o.last = last_i;
    if (all_s.cnt == '0 && last_i) begin
      res_o.cnt = bed_pkg::CntW'(1);
    end else begin
      res_o.cnt = all_s.cnt;
    end
  end

  // Drop back to idle at the end of the string
  always_comb begin
    if (last_i) begin
      phase_n  = PhIdle;
      acc_n    = '0;
      letter_n = '0;
    end else begin
      phase_n  = phase_d;
      acc_n    = acc_d;
      letter_n = letter_d;
    end
  end

  // Hold the escape state, advance on each decoded item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      acc_q    <= '0;
      letter_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_n;
      acc_q    <= acc_n;
      letter_q <= letter_n;
    end
  end

endmodule

[rtl/core/bed_outbuf.sv]
module bed_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  bed_pkg::res_t res_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          has_byte_o,
  output logic          out_last_o
);

  logic [bed_pkg::CntW-1:0]               cnt_q;
  logic [bed_pkg::MaxRes-1:0][7:0]        data_q;
  logic                                   has_q;
  logic                                   last_q;
  logic                                   take;

  assign out_valid_o = (cnt_q != '0);
  assign take        = out_valid_o && !out_stall_i;
  assign ready_o     = (cnt_q == '0) || (cnt_q == bed_pkg::CntW'(1) && take);

  assign out_byte_o  = data_q[0];
  assign has_byte_o  = has_q;
  assign out_last_o  = last_q && (cnt_q == bed_pkg::CntW'(1));

  // Count of items still to deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - bed_pkg::CntW'(1);
    end
  end

  // Load a new group of items, shift one out per delivered item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
      has_q  <= res_i.has;
      last_q <= res_i.last;
    end else if (take) begin
      data_q <= {8'h00, data_q[bed_pkg::MaxRes-1:1]};
    end
  end

endmodule

[rtl/core/backslash_escape_decoder_top.sv]
// A result item is presented once its input item has passed the input register
// and been loaded into the output buffer.
// Throughput: one input item per cycle while each item yields at most one result
// and the output is not stalled. An item with n results (up to four, e.g. a
// three-byte UTF-8 sequence) holds the output buffer, and input is stalled until
// the last one is taken. Reset (rst_ni, asynchronous, active low) empties both
// stages and returns the escape state to idle.
module backslash_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       out_last_o
);

  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          accept;
  logic          advance;
  logic          ob_ready;
  bed_pkg::res_t res;

  assign advance    = in_vld_q && ob_ready;
  assign in_stall_o = in_vld_q && !ob_ready;
  assign accept     = in_valid_i && !in_stall_o;

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  bed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  bed_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && (res.cnt != '0)),
    .res_i       (res),
    .ready_o     (ob_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .has_byte_o  (has_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

[rtl/core/bed_checker.sv]
module bed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       has_byte_o,
  input logic       out_last_o
);

  // An empty end marker only closes a string
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_last_o)
    else $error("empty item without out_last");

  // An empty end marker carries a zero byte
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> out_byte_o == 8'h00)
    else $error("empty item with nonzero byte");

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(has_byte_o) && $stable(out_last_o))
    else $error("stalled result item changed");

  // A stalled input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i) &&
    $stable(in_last_i))
    else $error("stalled input item changed");

endmodule

bind backslash_escape_decoder_top bed_checker u_bed_checker (.*);
